/* hw/rtl/bds_pkg.sv */
// Shared types, constants and field layout for the ballistic deposition block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package bds_pkg;

   localparam int MaxColumns   = 256;
   localparam int MaxRows      = 256;
   localparam int FractionBits = 12;

   localparam int HeightW    = 32;
   localparam int IncW       = FractionBits + 1;
   localparam int OpW        = 2;
   localparam int IdxW       = 8;
   localparam int CfgW       = 9;
   localparam int CsrDataW   = 32;
   localparam int CsrAddrW   = 3;
   localparam int QueueDepth = 2;

   localparam int ReqDataW = 64;
   localparam int ReqUserW = OpW;
   localparam int RspDataW = HeightW;
   localparam int RspUserW = 1;

   localparam int RowLsb = 0;
   localparam int ColLsb = RowLsb + IdxW;
   localparam int IncLsb = ColLsb + IdxW;
   localparam int WhLsb  = IncLsb + IncW;

   localparam int KindW = 2;

   localparam logic [OpW-1:0] OP_DEPOSIT = 2'd0;
   localparam logic [OpW-1:0] OP_WRITE   = 2'd1;
   localparam logic [OpW-1:0] OP_READ    = 2'd2;

   localparam logic REG_GRID_COLUMNS = 1'b0;
   localparam logic REG_GRID_ROWS    = 1'b1;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [KindW-1:0] {
      KIND_DEPOSIT,
      KIND_WRITE,
      KIND_READ,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      logic [CfgW-1:0] grid_columns;
      logic [CfgW-1:0] grid_rows;
   } cfg_type;

endpackage

/* hw/rtl/bds_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
// Depends on bds_pkg for its default width and depth.
module bds_ram #(
   parameter int Width = bds_pkg::HeightW,
   parameter int Depth = bds_pkg::MaxRows * bds_pkg::MaxColumns
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   output logic [Width-1:0]         rd_data_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_a_ff;
   logic [Width-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hw/rtl/bds_fifo.sv */
// Short command queue between the front and back parts of the block.
// Depends on bds_pkg for its default depth and word width.
module bds_fifo #(
   parameter int Width = bds_pkg::KindW + bds_pkg::HeightW
                         + 5 * $clog2(bds_pkg::MaxRows * bds_pkg::MaxColumns),
   parameter int Depth = bds_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             pop_valid
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   logic [Width-1:0] entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/bds_front.sv */
// Front part: takes request words, checks them against the grid size and works out
// the cell and neighbor addresses. Depends on bds_pkg; feeds bds_fifo.
module bds_front #(
   parameter int MAX_COLUMNS = bds_pkg::MaxColumns,
   parameter int MAX_ROWS    = bds_pkg::MaxRows
) (
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [bds_pkg::ReqDataW-1:0]          req_tdata,
   input  logic [bds_pkg::ReqUserW-1:0]          req_tuser,
   input  bds_pkg::cfg_type                      cfg,
   input  logic                                  clearing,
   input  logic                                  q_ready,
   output logic                                  q_push,
   output logic [bds_pkg::KindW + bds_pkg::HeightW
                 + 5 * $clog2(MAX_ROWS * MAX_COLUMNS) - 1:0] q_data
);

   localparam int RowW  = $clog2(MAX_ROWS);
   localparam int ColW  = $clog2(MAX_COLUMNS);
   localparam int AddrW = $clog2(MAX_ROWS * MAX_COLUMNS);
   localparam int RSzW  = $clog2(MAX_ROWS + 1);
   localparam int CSzW  = $clog2(MAX_COLUMNS + 1);
   localparam logic [AddrW-1:0] ColStride = AddrW'(MAX_COLUMNS);

   logic [RSzW-1:0]                nr;
   logic [CSzW-1:0]                nc;
   logic [bds_pkg::IdxW-1:0]       row;
   logic [bds_pkg::IdxW-1:0]       col;
   logic [bds_pkg::IncW-1:0]       inc;
   logic [bds_pkg::HeightW-1:0]    wh;
   logic [RowW-1:0]                ri, ru, rd, r_last;
   logic [ColW-1:0]                ci, cl, cr, c_last;
   logic                           in_range;
   bds_pkg::kind_type              kind;
   logic [bds_pkg::HeightW-1:0]    operand;

   function automatic logic [AddrW-1:0] cell_addr(input logic [RowW-1:0] r,
                                                  input logic [ColW-1:0] c);
      return AddrW'(r) * ColStride + AddrW'(c);
   endfunction

   always_comb begin
      if (cfg.grid_rows == '0) begin
         nr = RSzW'(1);
      end else if (cfg.grid_rows > MAX_ROWS) begin
         nr = RSzW'(MAX_ROWS);
      end else begin
         nr = RSzW'(cfg.grid_rows);
      end
      if (cfg.grid_columns == '0) begin
         nc = CSzW'(1);
      end else if (cfg.grid_columns > MAX_COLUMNS) begin
         nc = CSzW'(MAX_COLUMNS);
      end else begin
         nc = CSzW'(cfg.grid_columns);
      end
   end

   assign row = req_tdata[bds_pkg::RowLsb +: bds_pkg::IdxW];
   assign col = req_tdata[bds_pkg::ColLsb +: bds_pkg::IdxW];
   assign inc = req_tdata[bds_pkg::IncLsb +: bds_pkg::IncW];
   assign wh  = req_tdata[bds_pkg::WhLsb +: bds_pkg::HeightW];

   assign in_range = (row < nr) && (col < nc);

   assign ri     = RowW'(row);
   assign ci     = ColW'(col);
   assign r_last = RowW'(nr - RSzW'(1));
   assign c_last = ColW'(nc - CSzW'(1));
   assign ru     = (ri == '0) ? r_last : ri - RowW'(1);
   assign rd     = (ri == r_last) ? '0 : ri + RowW'(1);
   assign cl     = (ci == '0) ? c_last : ci - ColW'(1);
   assign cr     = (ci == c_last) ? '0 : ci + ColW'(1);

   always_comb begin
      if (!in_range) begin
         kind = bds_pkg::KIND_BAD;
      end else begin
         case (req_tuser)
            bds_pkg::OP_DEPOSIT: kind = bds_pkg::KIND_DEPOSIT;
            bds_pkg::OP_WRITE:   kind = bds_pkg::KIND_WRITE;
            default:             kind = bds_pkg::KIND_READ;
         endcase
      end
      operand = (kind == bds_pkg::KIND_WRITE) ? wh : bds_pkg::HeightW'(inc);
   end

   assign q_data = {kind, operand, cell_addr(ri, ci), cell_addr(ru, ci), cell_addr(rd, ci),
                    cell_addr(ri, cl), cell_addr(ri, cr)};

   assign req_tready = q_ready && !clearing;
   assign q_push     = req_tvalid && req_tready;

endmodule

/* hw/rtl/bds_back.sv */
// Back part: runs queued commands against the height grid and holds the result register.
// Depends on bds_pkg and bds_ram; takes its commands from bds_fifo.
module bds_back #(
   parameter int MAX_COLUMNS = bds_pkg::MaxColumns,
   parameter int MAX_ROWS    = bds_pkg::MaxRows
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  logic [bds_pkg::KindW + bds_pkg::HeightW
                 + 5 * $clog2(MAX_ROWS * MAX_COLUMNS) - 1:0] q_data,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [bds_pkg::RspDataW-1:0]          rsp_tdata,
   output logic [bds_pkg::RspUserW-1:0]          rsp_tuser,
   output logic                                  clearing
);

   localparam int AddrW = $clog2(MAX_ROWS * MAX_COLUMNS);
   localparam int HW    = bds_pkg::HeightW;
   localparam int CmdW  = bds_pkg::KindW + HW + 5 * AddrW;
   localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_ROWS * MAX_COLUMNS - 1);
   localparam logic [HW-1:0]    HeightMax = {1'b0, {(HW - 1){1'b1}}};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIRST,
      ST_SECOND,
      ST_THIRD
   } state_type;

   state_type          state_ff, state_in;
   logic [CmdW-1:0]    cmd_ff, cmd_in;
   logic [HW-1:0]      m_ff, m_in;
   logic [AddrW-1:0]   clear_ff, clear_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0]      rsp_height_ff, rsp_height_in;
   logic               rsp_status_ff, rsp_status_in;

   bds_pkg::kind_type  head_kind, cmd_kind;
   logic [HW-1:0]      head_operand, cmd_operand;
   logic [AddrW-1:0]   head_c, head_u, cmd_c, cmd_d, cmd_l, cmd_r;
   logic               out_free;
   logic               wr_en;
   logic [AddrW-1:0]   wr_addr, rd_addr_a, rd_addr_b;
   logic [HW-1:0]      wr_data, rd_data_a, rd_data_b;
   logic [HW-1:0]      sum, sat_sum, result;

   function automatic logic [HW-1:0] smax(input logic [HW-1:0] a, input logic [HW-1:0] b);
      return ($signed(a) > $signed(b)) ? a : b;
   endfunction

   assign head_kind    = bds_pkg::kind_type'(q_data[CmdW-1 -: bds_pkg::KindW]);
   assign head_operand = q_data[CmdW-bds_pkg::KindW-1 -: HW];
   assign head_c       = q_data[5*AddrW-1 -: AddrW];
   assign head_u       = q_data[4*AddrW-1 -: AddrW];
   assign cmd_kind     = bds_pkg::kind_type'(cmd_ff[CmdW-1 -: bds_pkg::KindW]);
   assign cmd_operand  = cmd_ff[CmdW-bds_pkg::KindW-1 -: HW];
   assign cmd_c        = cmd_ff[5*AddrW-1 -: AddrW];
   assign cmd_d        = cmd_ff[3*AddrW-1 -: AddrW];
   assign cmd_l        = cmd_ff[2*AddrW-1 -: AddrW];
   assign cmd_r        = cmd_ff[AddrW-1:0];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sum      = rd_data_a + cmd_operand;
   assign sat_sum  = (!rd_data_a[HW-1] && sum[HW-1]) ? HeightMax : sum;
   assign result   = smax(m_ff, rd_data_a);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      m_in          = m_ff;
      clear_in      = clear_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_height_in = rsp_height_ff;
      rsp_status_in = rsp_status_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = head_c;
      wr_data       = head_operand;
      rd_addr_a     = head_c;
      rd_addr_b     = head_u;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clear_ff;
            wr_data = '0;
            if (clear_ff == LastAddr) begin
               state_in = ST_IDLE;
            end else begin
               clear_in = clear_ff + AddrW'(1);
            end
         end
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               cmd_in = q_data;
               case (head_kind)
                  bds_pkg::KIND_WRITE: begin
                     wr_en         = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_height_in = head_operand;
                     rsp_status_in = bds_pkg::STATUS_DONE;
                  end
                  bds_pkg::KIND_BAD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_height_in = '0;
                     rsp_status_in = bds_pkg::STATUS_RANGE;
                  end
                  default: begin
                     state_in = ST_FIRST;
                  end
               endcase
            end
         end
         ST_FIRST: begin
            rd_addr_a = cmd_d;
            rd_addr_b = cmd_l;
            if (cmd_kind == bds_pkg::KIND_DEPOSIT) begin
               m_in     = smax(sat_sum, rd_data_b);
               state_in = ST_SECOND;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = rd_data_a;
               rsp_status_in = bds_pkg::STATUS_DONE;
               state_in      = ST_IDLE;
            end
         end
         ST_SECOND: begin
            rd_addr_a = cmd_r;
            rd_addr_b = cmd_r;
            m_in      = smax(m_ff, smax(rd_data_a, rd_data_b));
            state_in  = ST_THIRD;
         end
         ST_THIRD: begin
            wr_en         = 1'b1;
            wr_addr       = cmd_c;
            wr_data       = result;
            rsp_valid_in  = 1'b1;
            rsp_height_in = result;
            rsp_status_in = bds_pkg::STATUS_DONE;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_ff      <= clear_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmd_ff        <= cmd_in;
         m_ff          <= m_in;
         rsp_height_ff <= rsp_height_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   bds_ram #(
      .Width (HW),
      .Depth (MAX_ROWS * MAX_COLUMNS)
   ) u_grid (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_height_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign clearing   = (state_ff == ST_CLEAR);

endmodule

/* hw/rtl/ballistic_deposition_step_top.sv */
// Top level of the ballistic deposition height grid: register port, front, queue, back.
// Depends on bds_pkg, bds_front, bds_fifo, bds_back and bds_ram.
//
//   Channel   Direction  Handshake                   Payload
//   req_      in         req_tvalid / req_tready     tdata: row, col, increment, write_height
//   rsp_      out        rsp_tvalid / rsp_tready     tdata: height; tuser: status
//   csr_      in         psel / penable / pready     grid_columns at 0x0, grid_rows at 0x4
//
// A deposit in the back part reads five grid cells over the two read ports of the grid memory
// in the idle, first and second states, then writes the new height in the third. A read ends in
// the first state; a write or an out-of-range word is done in the idle state. After reset a
// clearing pass writes zero to all MAX_ROWS*MAX_COLUMNS cells (65536 by default) and no word is
// accepted meanwhile. The queue keeps taking words while a result waits; a new command starts
// when the result register is free.
module ballistic_deposition_step_top #(
   parameter int MAX_COLUMNS = bds_pkg::MaxColumns,
   parameter int MAX_ROWS    = bds_pkg::MaxRows
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // row [7:0], col [15:8], increment [28:16], write_height [60:29], zero fill [63:61]
   input  logic [bds_pkg::ReqDataW-1:0]   req_tdata,
   // opcode [1:0]
   input  logic [bds_pkg::ReqUserW-1:0]   req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // height [31:0]
   output logic [bds_pkg::RspDataW-1:0]   rsp_tdata,
   // status [0]
   output logic [bds_pkg::RspUserW-1:0]   rsp_tuser,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bds_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [bds_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [bds_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                           csr_pready
);

   localparam int AddrW = $clog2(MAX_ROWS * MAX_COLUMNS);
   localparam int CmdW  = bds_pkg::KindW + bds_pkg::HeightW + 5 * AddrW;
   localparam logic [bds_pkg::CfgW-1:0] SizeReset = bds_pkg::CfgW'(256);

   bds_pkg::cfg_type   cfg_ff, cfg_in;
   logic               csr_write;
   logic               q_push, q_ready, q_pop, q_valid;
   logic [CmdW-1:0]    q_push_data, q_pop_data;
   logic               clearing;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            bds_pkg::REG_GRID_COLUMNS: cfg_in.grid_columns = csr_pwdata[bds_pkg::CfgW-1:0];
            bds_pkg::REG_GRID_ROWS:    cfg_in.grid_rows    = csr_pwdata[bds_pkg::CfgW-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
      case (csr_paddr[2])
         bds_pkg::REG_GRID_COLUMNS: csr_prdata = bds_pkg::CsrDataW'(cfg_ff.grid_columns);
         bds_pkg::REG_GRID_ROWS:    csr_prdata = bds_pkg::CsrDataW'(cfg_ff.grid_rows);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_columns <= SizeReset;
         cfg_ff.grid_rows    <= SizeReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bds_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .clearing   (clearing),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_data     (q_push_data)
   );

   bds_fifo #(
      .Width (CmdW),
      .Depth (bds_pkg::QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_data   (q_pop_data),
      .pop_valid  (q_valid)
   );

   bds_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .clearing   (clearing)
   );

   assert property (@(posedge clock) disable iff (reset) clearing |-> !req_tready)
      else $error("Request word accepted during the clearing pass.");

   assert property (@(posedge clock) disable iff (reset) clearing |-> !rsp_tvalid)
      else $error("Result word offered during the clearing pass.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("Out-of-range result word carries a nonzero height.");

   assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_valid) |-> 1'b0)
      else $error("Back part popped an empty command queue.");

endmodule

/* tb/sv/bds_grid_checker.sv */
`timescale 1ns / 1ps
// Checker for the ballistic deposition block: keeps its own height grid and register copies,
// predicts each result from the accepted request words and compares it with the result words.
// Depends on bds_pkg for widths, field positions, opcodes, register indexes and status codes.
module bds_grid_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [bds_pkg::ReqDataW-1:0]   req_tdata,
   input  logic [bds_pkg::ReqUserW-1:0]   req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [bds_pkg::RspDataW-1:0]   rsp_tdata,
   input  logic [bds_pkg::RspUserW-1:0]   rsp_tuser,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bds_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [bds_pkg::CsrDataW-1:0]   csr_pwdata,
   input  logic                           csr_pready,
   output int unsigned                    fail_count,
   output int unsigned                    pending_count
);
   import bds_pkg::*;

   typedef struct packed {
      logic [HeightW-1:0] height;
      logic               status;
   } cell_result_t;

   logic signed [HeightW-1:0] heights [0:MaxRows*MaxColumns-1];
   logic [CfgW-1:0]           cfg_columns;
   logic [CfgW-1:0]           cfg_rows;
   cell_result_t              expected_heights [$];
   int unsigned               mismatches;

   initial begin
      mismatches    = 0;
      fail_count    = 0;
      pending_count = 0;
      cfg_columns   = CfgW'(MaxColumns);
      cfg_rows      = CfgW'(MaxRows);
   end

   function automatic int unsigned used_size(input logic [CfgW-1:0] value,
                                             input int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   // Applies one request word to the grid copy and returns the result it must produce.
   function automatic cell_result_t next_cell_height(input logic [OpW-1:0] opcode,
                                                     input int unsigned row,
                                                     input int unsigned col,
                                                     input logic [IncW-1:0] increment,
                                                     input logic signed [HeightW-1:0] new_height);
      int unsigned               n_cols;
      int unsigned               n_rows;
      int unsigned               here;
      int unsigned               up;
      int unsigned               down;
      int unsigned               left;
      int unsigned               right;
      longint                    raised;
      logic signed [HeightW-1:0] best;
      cell_result_t              outcome;
      n_cols = used_size(cfg_columns, MaxColumns);
      n_rows = used_size(cfg_rows, MaxRows);
      outcome.height = '0;
      outcome.status = STATUS_RANGE;
      if (row >= n_rows || col >= n_cols) return outcome;
      here = row * MaxColumns + col;
      outcome.status = STATUS_DONE;
      if (opcode == OP_DEPOSIT) begin
         up    = ((row == 0) ? n_rows - 1 : row - 1) * MaxColumns + col;
         down  = ((row == n_rows - 1) ? 0 : row + 1) * MaxColumns + col;
         left  = row * MaxColumns + ((col == 0) ? n_cols - 1 : col - 1);
         right = row * MaxColumns + ((col == n_cols - 1) ? 0 : col + 1);
         raised = longint'(heights[here]) + longint'(increment);
         if (raised > 64'sd2147483647) raised = 64'sd2147483647;
         best = raised[HeightW-1:0];
         if (heights[up] > best) best = heights[up];
         if (heights[left] > best) best = heights[left];
         if (heights[right] > best) best = heights[right];
         if (heights[down] > best) best = heights[down];
         heights[here] = best;
      end else if (opcode == OP_WRITE) begin
         heights[here] = new_height;
      end
      outcome.height = heights[here];
      return outcome;
   endfunction

   always @(posedge clock) begin
      cell_result_t want;
      if (reset) begin
         for (int i = 0; i < MaxRows * MaxColumns; i++) heights[i] = '0;
         cfg_columns = CfgW'(MaxColumns);
         cfg_rows    = CfgW'(MaxRows);
         expected_heights.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[CsrAddrW-1:2] == REG_GRID_COLUMNS)
               cfg_columns = csr_pwdata[CfgW-1:0];
            else if (csr_paddr[CsrAddrW-1:2] == REG_GRID_ROWS)
               cfg_rows = csr_pwdata[CfgW-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_heights.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with nothing expected: height %h status %0d",
                           $realtime, rsp_tdata, rsp_tuser[0]);
            end else begin
               want = expected_heights.pop_front();
               if (rsp_tdata !== want.height || rsp_tuser[0] !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: height expected %h got %h, status expected %0d got %0d",
                              $realtime, want.height, rsp_tdata, want.status, rsp_tuser[0]);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_heights.push_back(next_cell_height(req_tuser,
                                                        req_tdata[RowLsb +: IdxW],
                                                        req_tdata[ColLsb +: IdxW],
                                                        req_tdata[IncLsb +: IncW],
                                                        req_tdata[WhLsb +: HeightW]));
      end
      fail_count    <= mismatches;
      pending_count <= expected_heights.size();
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the ballistic deposition testbench: clock, reset, request, result and register stimulus.
// Depends on bds_pkg, ballistic_deposition_step_top and bds_grid_checker, which gives the verdict input.
module tb_top;
   import bds_pkg::*;

   localparam int PhaseWords = 160;
   localparam int HoldCycles = 600;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata;
   logic [ReqUserW-1:0]   req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RspDataW-1:0]   rsp_tdata;
   logic [RspUserW-1:0]   rsp_tuser;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CsrAddrW-1:0]   csr_paddr;
   logic [CsrDataW-1:0]   csr_pwdata;
   logic [CsrDataW-1:0]   csr_prdata;
   logic                  csr_pready;
   int unsigned           fail_count;
   int unsigned           pending_count;
   int unsigned           word_count;
   int unsigned           use_columns;
   int unsigned           use_rows;

   ballistic_deposition_step_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   bds_grid_checker grid_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   // Mostly short gaps, now and then a long one, and none at all when quiet is set.
   function automatic int unsigned pick_gap(input bit quiet);
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   task automatic send_word(input logic [OpW-1:0] opcode, input logic [IdxW-1:0] row,
                            input logic [IdxW-1:0] col, input logic [IncW-1:0] increment,
                            input logic [HeightW-1:0] new_height);
      logic [ReqDataW-1:0] word;
      int unsigned         gap;
      word = '0;
      word[RowLsb +: IdxW]   = row;
      word[ColLsb +: IdxW]   = col;
      word[IncLsb +: IncW]   = increment;
      word[WhLsb +: HeightW] = new_height;
      req_tdata  <= word;
      req_tuser  <= opcode;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      word_count++;
      gap = pick_gap((word_count / 128) % 4 == 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_register(input logic index, input int unsigned value);
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(input int unsigned columns, input int unsigned rows);
      drain();
      write_register(REG_GRID_COLUMNS, columns);
      write_register(REG_GRID_ROWS, rows);
      use_columns = (columns == 0) ? 1 : (columns > MaxColumns) ? MaxColumns : columns;
      use_rows    = (rows == 0) ? 1 : (rows > MaxRows) ? MaxRows : rows;
   endtask

   // Mostly in-range addresses so that deposits pile up on each other, with a few strays.
   task automatic send_random_word();
      logic [OpW-1:0]     opcode;
      logic [IdxW-1:0]    row;
      logic [IdxW-1:0]    col;
      logic [IncW-1:0]    increment;
      logic [HeightW-1:0] new_height;
      int unsigned        roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) opcode = OP_DEPOSIT;
      else if (roll < 65) opcode = OP_WRITE;
      else if (roll < 95) opcode = OP_READ;
      else opcode = KIND_BAD;
      row = ($urandom_range(0, 9) < 9) ? $urandom_range(0, use_rows - 1) : $urandom_range(0, 255);
      col = ($urandom_range(0, 9) < 9) ? $urandom_range(0, use_columns - 1)
                                       : $urandom_range(0, 255);
      roll = $urandom_range(0, 99);
      if (roll < 70) increment = $urandom_range(0, 4096);
      else if (roll < 90) increment = $urandom_range(0, 64);
      else increment = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 40) new_height = $urandom_range(0, 65536);
      else if (roll < 60) new_height = $urandom;
      else if (roll < 80) new_height = 32'h7FFF_FFFF - $urandom_range(0, 8191);
      else if (roll < 90) new_height = -$urandom_range(0, 65535);
      else new_height = 32'h8000_0000 + $urandom_range(0, 8191);
      send_word(opcode, row, col, increment, new_height);
   endtask

   initial begin : receiver
      int unsigned stall;
      int unsigned taken;
      int unsigned next_hold;
      stall     = 0;
      taken     = 0;
      next_hold = 80;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         if (taken >= next_hold) begin
            next_hold += 920;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else if (stall != 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = pick_gap((taken / 100) % 4 == 1);
         end
      end
   end

   initial begin
      int unsigned phase_columns [12];
      int unsigned phase_rows [12];
      phase_columns = '{256, 1, 2, 3, 16, 7, 1, 300, 0, 511, 37, 256};
      phase_rows    = '{256, 1, 2, 5, 8, 1, 9, 2, 4, 511, 200, 1};
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      word_count  = 0;
      use_columns = MaxColumns;
      use_rows    = MaxRows;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full-size grid: corners, saturation, wrap-around in both directions, unused opcode.
      send_word(OP_READ, 8'd0, 8'd0, '0, '0);
      send_word(OP_READ, 8'd255, 8'd255, '0, '0);
      send_word(OP_WRITE, 8'd0, 8'd0, '0, 32'h7FFF_FFFF);
      send_word(OP_DEPOSIT, 8'd0, 8'd0, 13'h1FFF, '0);
      send_word(OP_WRITE, 8'd255, 8'd255, '0, 32'h8000_0000);
      send_word(KIND_BAD, 8'd255, 8'd255, '0, '0);
      send_word(OP_DEPOSIT, 8'd0, 8'd255, 13'd0, '0);
      send_word(OP_DEPOSIT, 8'd255, 8'd0, 13'd4096, '0);
      send_word(OP_WRITE, 8'd170, 8'd85, 13'h1555, 32'hAAAA_5555);
      send_word(OP_WRITE, 8'd85, 8'd170, 13'h0AAA, 32'h5555_AAAA);
      send_word(OP_WRITE, 8'd20, 8'd20, '0, -32'sd5000);
      send_word(OP_DEPOSIT, 8'd20, 8'd20, 13'd4096, '0);
      send_word(OP_DEPOSIT, 8'd100, 8'd100, 13'd4096, '0);

      // Small grid with addresses just outside it.
      set_grid(3, 5);
      send_word(OP_DEPOSIT, 8'd4, 8'd2, 13'd100, '0);
      send_word(OP_WRITE, 8'd5, 8'd0, '0, 32'h1234_5678);
      send_word(OP_READ, 8'd0, 8'd3, '0, '0);
      send_word(OP_DEPOSIT, 8'd255, 8'd255, 13'd1, '0);

      // Zero sizes act as a single cell that is its own neighbor.
      set_grid(0, 0);
      send_word(OP_DEPOSIT, 8'd0, 8'd0, 13'd100, '0);
      send_word(OP_DEPOSIT, 8'd0, 8'd0, 13'h1FFF, '0);
      send_word(OP_READ, 8'd0, 8'd1, '0, '0);
      send_word(OP_READ, 8'd1, 8'd0, '0, '0);

      for (int p = 0; p < 12; p++) begin
         set_grid(phase_columns[p], phase_rows[p]);
         repeat (PhaseWords) send_random_word();
      end

      drain();
      repeat (16) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
